FILE: rtl/hbp_pkg.sv
// ----------------------------------------------------------------------------
// hbp_pkg
// Shared types, register map and counter helpers for the hybrid predictor.
// ----------------------------------------------------------------------------
package hbp_pkg;

    localparam int APB_AW = 5;

    localparam logic [2:0] REG_MODE         = 3'd0;
    localparam logic [2:0] REG_BIMODAL_BITS = 3'd1;
    localparam logic [2:0] REG_GSHARE_BITS  = 3'd2;
    localparam logic [2:0] REG_HISTORY_BITS = 3'd3;
    localparam logic [2:0] REG_CHOOSER_BITS = 3'd4;

    localparam logic [1:0] MODE_BIMODAL = 2'd0;
    localparam logic [1:0] MODE_GSHARE  = 2'd1;
    localparam logic [1:0] MODE_HYBRID  = 2'd2;

    localparam logic [1:0] CTR_MAX         = 2'd3;
    localparam logic [1:0] CTR_MIN         = 2'd0;
    localparam logic [1:0] CTR_WEAK_TAKEN  = 2'd2;
    localparam logic [1:0] CTR_FAVOR_BIMOD = 2'd1;

    localparam logic [1:0] RST_MODE      = MODE_BIMODAL;
    localparam logic [3:0] RST_BIMOD_BITS = 4'd12;
    localparam logic [3:0] RST_GSH_BITS   = 4'd12;
    localparam logic [3:0] RST_HIST_BITS  = 4'd8;
    localparam logic [3:0] RST_CHS_BITS   = 4'd12;

    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] bimodal_index_bits;
        logic [3:0] gshare_index_bits;
        logic [3:0] history_bits;
        logic [3:0] chooser_index_bits;
    } t_cfg;

    function automatic logic [1:0] f_train(input logic [1:0] ctr, input logic up);
        logic [1:0] res;
        res = ctr;
        if (up) begin
            if (ctr != CTR_MAX) res = ctr + 2'd1;
        end else begin
            if (ctr != CTR_MIN) res = ctr - 2'd1;
        end
        return res;
    endfunction

endpackage

FILE: rtl/hbp_if.sv
// ----------------------------------------------------------------------------
// hbp_br_if / hbp_res_if
// Valid/ready channels for branch items and prediction results.
// ----------------------------------------------------------------------------
interface hbp_br_if;
    logic        valid;
    logic        ready;
    logic [31:0] branch_address;
    logic        taken;

    modport source (output valid, output branch_address, output taken, input ready);
    modport sink   (input valid, input branch_address, input taken, output ready);
endinterface

interface hbp_res_if;
    logic        valid;
    logic        ready;
    logic        predicted_taken;
    logic        mispredicted;
    logic        used_gshare;
    logic [31:0] prediction_total;
    logic [31:0] miss_total;

    modport source (output valid, output predicted_taken, output mispredicted,
                    output used_gshare, output prediction_total, output miss_total,
                    input ready);
    modport sink   (input valid, input predicted_taken, input mispredicted,
                    input used_gshare, input prediction_total, input miss_total,
                    output ready);
endinterface

FILE: rtl/hbp_ram.sv
// ----------------------------------------------------------------------------
// hbp_ram
// Single write port, single registered read port counter memory.
// ----------------------------------------------------------------------------
module hbp_ram #(
    parameter int AW = 12,
    parameter int DW = 2
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (i_re) r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/hbp_regs.sv
// ----------------------------------------------------------------------------
// hbp_regs
// APB configuration registers: mode and table/history widths.
// ----------------------------------------------------------------------------
module hbp_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hbp_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output hbp_pkg::t_cfg              o_cfg
);

    hbp_pkg::t_cfg r_cfg;
    logic [2:0]    reg_idx;
    logic          wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode               <= hbp_pkg::RST_MODE;
            r_cfg.bimodal_index_bits <= hbp_pkg::RST_BIMOD_BITS;
            r_cfg.gshare_index_bits  <= hbp_pkg::RST_GSH_BITS;
            r_cfg.history_bits       <= hbp_pkg::RST_HIST_BITS;
            r_cfg.chooser_index_bits <= hbp_pkg::RST_CHS_BITS;
        end else if (wr_en) begin
            unique case (reg_idx)
                hbp_pkg::REG_MODE:         r_cfg.mode               <= pwdata[1:0];
                hbp_pkg::REG_BIMODAL_BITS: r_cfg.bimodal_index_bits <= pwdata[3:0];
                hbp_pkg::REG_GSHARE_BITS:  r_cfg.gshare_index_bits  <= pwdata[3:0];
                hbp_pkg::REG_HISTORY_BITS: r_cfg.history_bits       <= pwdata[3:0];
                hbp_pkg::REG_CHOOSER_BITS: r_cfg.chooser_index_bits <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            hbp_pkg::REG_MODE:         prdata = {30'd0, r_cfg.mode};
            hbp_pkg::REG_BIMODAL_BITS: prdata = {28'd0, r_cfg.bimodal_index_bits};
            hbp_pkg::REG_GSHARE_BITS:  prdata = {28'd0, r_cfg.gshare_index_bits};
            hbp_pkg::REG_HISTORY_BITS: prdata = {28'd0, r_cfg.history_bits};
            hbp_pkg::REG_CHOOSER_BITS: prdata = {28'd0, r_cfg.chooser_index_bits};
            default:                   prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/hbp_index.sv
// ----------------------------------------------------------------------------
// hbp_index
// Table index hashing and the global history register.
// ----------------------------------------------------------------------------
module hbp_index #(
    parameter int BI_W = 12,
    parameter int GI_W = 12,
    parameter int CI_W = 12
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hbp_pkg::t_cfg   i_cfg,
    input  logic            i_accept,
    input  logic [31:0]     i_addr,
    input  logic            i_taken,
    output logic [BI_W-1:0] o_bi,
    output logic [GI_W-1:0] o_gi,
    output logic [CI_W-1:0] o_ci
);

    localparam int BB_W = $clog2(BI_W + 1);
    localparam int GB_W = $clog2(GI_W + 1);
    localparam int CB_W = $clog2(CI_W + 1);

    logic [GI_W-1:0] r_hist;
    logic [GI_W-1:0] n_hist;
    logic [29:0]     word_addr;
    logic [BB_W-1:0] bb;
    logic [GB_W-1:0] gb;
    logic [GB_W-1:0] hb;
    logic [CB_W-1:0] cb;
    logic [GB_W-1:0] shamt;
    logic [BI_W-1:0] bmask;
    logic [GI_W-1:0] gmask;
    logic [GI_W-1:0] hmask;
    logic [CI_W-1:0] cmask;
    logic [GI_W-1:0] hist;
    logic [GI_W-1:0] hist_sh;
    logic            hist_upd;

    assign word_addr = i_addr[31:2];

    always_comb begin
        if (int'(i_cfg.bimodal_index_bits) > BI_W) bb = BB_W'(BI_W);
        else                                       bb = BB_W'(i_cfg.bimodal_index_bits);
        if (int'(i_cfg.gshare_index_bits) > GI_W)  gb = GB_W'(GI_W);
        else                                       gb = GB_W'(i_cfg.gshare_index_bits);
        if (int'(i_cfg.chooser_index_bits) > CI_W) cb = CB_W'(CI_W);
        else                                       cb = CB_W'(i_cfg.chooser_index_bits);
        if (int'(i_cfg.history_bits) > int'(gb))   hb = gb;
        else                                       hb = GB_W'(i_cfg.history_bits);
    end

    always_comb begin
        for (int j = 0; j < BI_W; j++) bmask[j] = (j < int'(bb));
        for (int j = 0; j < GI_W; j++) gmask[j] = (j < int'(gb));
        for (int j = 0; j < GI_W; j++) hmask[j] = (j < int'(hb));
        for (int j = 0; j < CI_W; j++) cmask[j] = (j < int'(cb));
    end

    assign hist  = r_hist & hmask;
    assign shamt = gb - hb;

    assign o_bi = word_addr[BI_W-1:0] & bmask;
    assign o_ci = word_addr[CI_W-1:0] & cmask;
    assign o_gi = ((hist << shamt) ^ word_addr[GI_W-1:0]) & gmask;

    // newest outcome enters at the top of the active history window
    assign hist_sh = hist >> 1;
    always_comb begin
        for (int j = 0; j < GI_W; j++) begin
            n_hist[j] = (j + 1 == int'(hb)) ? i_taken : hist_sh[j];
        end
    end

    assign hist_upd = i_accept && (hb != '0)
                      && (i_cfg.mode == hbp_pkg::MODE_GSHARE
                          || i_cfg.mode == hbp_pkg::MODE_HYBRID);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (hist_upd) begin
            r_hist <= n_hist;
        end
    end

endmodule

FILE: rtl/hybrid_branch_predictor.sv
// Each branch passes the table read (stage 1), then the result register. Throughput: 1 branch per
// cycle unless stalled by the output or the clear; each table has one read and one write port, with
// the last write forwarded into the counter update so back-to-back hits on one entry stay exact.
// Reset: synchronous, active low. A clearing pass over every address of the widest table then
// rewrites every table entry; no branch is accepted until it ends. Config and history reset.
// ----------------------------------------------------------------------------
// hybrid_branch_predictor
// Bimodal / gshare / tournament predictor with saturating running totals.
// ----------------------------------------------------------------------------
module hybrid_branch_predictor #(
    parameter int BIMODAL_INDEX_MAX = 12,
    parameter int GSHARE_INDEX_MAX  = 12,
    parameter int CHOOSER_INDEX_MAX = 12,
    parameter int TOTAL_WIDTH       = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    hbp_br_if.sink                     i_branch,
    hbp_res_if.source                  o_result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hbp_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int BI_W  = BIMODAL_INDEX_MAX;
    localparam int GI_W  = GSHARE_INDEX_MAX;
    localparam int CI_W  = CHOOSER_INDEX_MAX;
    localparam int BG_W  = (BI_W > GI_W) ? BI_W : GI_W;
    localparam int CLR_W = (BG_W > CI_W) ? BG_W : CI_W;

    hbp_pkg::t_cfg cfg;

    logic [BI_W-1:0] bi;
    logic [GI_W-1:0] gi;
    logic [CI_W-1:0] ci;
    logic            in_ready;
    logic            accept;
    logic            s1_adv;
    logic            s1_fire;

    logic             r_clr_busy;
    logic [CLR_W-1:0] r_clr_addr;

    logic            r_s1_valid;
    logic [BI_W-1:0] r_s1_bi;
    logic [GI_W-1:0] r_s1_gi;
    logic [CI_W-1:0] r_s1_ci;
    logic            r_s1_taken;

    logic [1:0] b_rdata, g_rdata, c_rdata;
    logic [1:0] b_cnt, g_cnt, c_cnt;
    logic       bpred, gpred, use_g, pred, miss;

    logic            b_we, g_we, c_we;
    logic [BI_W-1:0] b_waddr;
    logic [GI_W-1:0] g_waddr;
    logic [CI_W-1:0] c_waddr;
    logic [1:0]      b_wdata, g_wdata, c_wdata;
    logic            b_we_item, g_we_item, c_we_item;

    logic            r_bf_en, r_gf_en, r_cf_en;
    logic [BI_W-1:0] r_bf_idx;
    logic [GI_W-1:0] r_gf_idx;
    logic [CI_W-1:0] r_cf_idx;
    logic [1:0]      r_bf_val, r_gf_val, r_cf_val;

    logic [TOTAL_WIDTH-1:0] r_br_cnt, r_miss_cnt;
    logic [TOTAL_WIDTH-1:0] n_br_cnt, n_miss_cnt;

    logic        r_out_valid;
    logic        r_out_pred;
    logic        r_out_miss;
    logic        r_out_used_g;
    logic [31:0] r_out_ptot;
    logic [31:0] r_out_mtot;

    hbp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    hbp_index #(
        .BI_W (BI_W),
        .GI_W (GI_W),
        .CI_W (CI_W)
    ) u_index (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (accept),
        .i_addr   (i_branch.branch_address),
        .i_taken  (i_branch.taken),
        .o_bi     (bi),
        .o_gi     (gi),
        .o_ci     (ci)
    );

    // ---- handshake ----
    assign s1_adv   = !r_out_valid || o_result.ready;
    assign in_ready = !r_clr_busy && (!r_s1_valid || s1_adv);
    assign accept   = i_branch.valid && in_ready;
    assign s1_fire  = r_s1_valid && s1_adv;
    assign i_branch.ready = in_ready;

    // ---- table clearing after reset ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == '1) r_clr_busy <= 1'b0;
        end
    end

    // ---- stage 1 ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_bi    <= bi;
            r_s1_gi    <= gi;
            r_s1_ci    <= ci;
            r_s1_taken <= i_branch.taken;
        end
    end

    hbp_ram #(.AW(BI_W), .DW(2)) u_bimodal (
        .i_clk (i_clk), .i_we (b_we), .i_waddr (b_waddr), .i_wdata (b_wdata),
        .i_re (accept), .i_raddr (bi), .o_rdata (b_rdata)
    );

    hbp_ram #(.AW(GI_W), .DW(2)) u_gshare (
        .i_clk (i_clk), .i_we (g_we), .i_waddr (g_waddr), .i_wdata (g_wdata),
        .i_re (accept), .i_raddr (gi), .o_rdata (g_rdata)
    );

    hbp_ram #(.AW(CI_W), .DW(2)) u_chooser (
        .i_clk (i_clk), .i_we (c_we), .i_waddr (c_waddr), .i_wdata (c_wdata),
        .i_re (accept), .i_raddr (ci), .o_rdata (c_rdata)
    );

    // last write to each table covers a read taken at the same edge
    assign b_cnt = (r_bf_en && r_bf_idx == r_s1_bi) ? r_bf_val : b_rdata;
    assign g_cnt = (r_gf_en && r_gf_idx == r_s1_gi) ? r_gf_val : g_rdata;
    assign c_cnt = (r_cf_en && r_cf_idx == r_s1_ci) ? r_cf_val : c_rdata;

    assign bpred = b_cnt[1];
    assign gpred = g_cnt[1];

    always_comb begin
        unique case (cfg.mode)
            hbp_pkg::MODE_GSHARE: use_g = 1'b1;
            hbp_pkg::MODE_HYBRID: use_g = c_cnt[1];
            default:              use_g = 1'b0;
        endcase
    end

    assign pred = use_g ? gpred : bpred;
    assign miss = pred != r_s1_taken;

    assign b_we_item = s1_fire && !use_g;
    assign g_we_item = s1_fire && use_g;
    assign c_we_item = s1_fire && (cfg.mode == hbp_pkg::MODE_HYBRID) && (gpred != bpred);

    assign b_we    = r_clr_busy || b_we_item;
    assign g_we    = r_clr_busy || g_we_item;
    assign c_we    = r_clr_busy || c_we_item;
    assign b_waddr = r_clr_busy ? r_clr_addr[BI_W-1:0] : r_s1_bi;
    assign g_waddr = r_clr_busy ? r_clr_addr[GI_W-1:0] : r_s1_gi;
    assign c_waddr = r_clr_busy ? r_clr_addr[CI_W-1:0] : r_s1_ci;
    assign b_wdata = r_clr_busy ? hbp_pkg::CTR_WEAK_TAKEN
                                : hbp_pkg::f_train(b_cnt, r_s1_taken);
    assign g_wdata = r_clr_busy ? hbp_pkg::CTR_WEAK_TAKEN
                                : hbp_pkg::f_train(g_cnt, r_s1_taken);
    assign c_wdata = r_clr_busy ? hbp_pkg::CTR_FAVOR_BIMOD
                                : hbp_pkg::f_train(c_cnt, gpred == r_s1_taken);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bf_en <= 1'b0;
            r_gf_en <= 1'b0;
            r_cf_en <= 1'b0;
        end else begin
            if (b_we) r_bf_en <= 1'b1;
            if (g_we) r_gf_en <= 1'b1;
            if (c_we) r_cf_en <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_we) begin
            r_bf_idx <= b_waddr;
            r_bf_val <= b_wdata;
        end
        if (g_we) begin
            r_gf_idx <= g_waddr;
            r_gf_val <= g_wdata;
        end
        if (c_we) begin
            r_cf_idx <= c_waddr;
            r_cf_val <= c_wdata;
        end
    end

    // ---- saturating totals ----
    assign n_br_cnt   = (r_br_cnt != '1) ? r_br_cnt + 1'b1 : r_br_cnt;
    assign n_miss_cnt = (miss && r_miss_cnt != '1) ? r_miss_cnt + 1'b1 : r_miss_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_br_cnt   <= '0;
            r_miss_cnt <= '0;
        end else if (s1_fire) begin
            r_br_cnt   <= n_br_cnt;
            r_miss_cnt <= n_miss_cnt;
        end
    end

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_pred   <= pred;
            r_out_miss   <= miss;
            r_out_used_g <= use_g;
            r_out_ptot   <= 32'(n_br_cnt);
            r_out_mtot   <= 32'(n_miss_cnt);
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.predicted_taken  = r_out_pred;
    assign o_result.mispredicted     = r_out_miss;
    assign o_result.used_gshare      = r_out_used_g;
    assign o_result.prediction_total = r_out_ptot;
    assign o_result.miss_total       = r_out_mtot;

    // ---- assertions ----
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !accept)
        else $error("branch transfer during table clear");

    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> r_out_valid)
        else $error("stage 1 item lost on the way to the result register");

    a_miss_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_miss_cnt <= r_br_cnt)
        else $error("miss total exceeds branch total");

    a_one_dir_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_clr_busy |-> !(b_we && g_we))
        else $error("bimodal and gshare trained by one branch");

    a_chooser_hybrid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_clr_busy && cfg.mode != hbp_pkg::MODE_HYBRID) |-> !c_we)
        else $error("chooser written outside hybrid mode");

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for hybrid_branch_predictor. A directed table covers
// reset state, address extremes, all modes and the index/history corner
// cases; a random part then runs loop-like branch streams with noise across
// many register settings. Every result transfer is checked field by field
// against an in-bench model of the counter tables, history and totals, or a directed row's values.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int         BIM_MAX       = 12;
    localparam int         GSH_MAX       = 12;
    localparam int         CHS_MAX       = 12;
    localparam logic [1:0] MODE_BIM_ALT  = 2'd3;
    localparam int         IDLE_LIMIT    = 20000;
    localparam int         SETTLE_CYC    = 4;
    localparam int         PHASES        = 12;
    localparam int         PHASE_ITEMS   = 150;
    localparam int         HOLD_CYC      = 200;
    localparam bit         ITEM_ROW      = 1'b0;
    localparam bit         CFG_ROW       = 1'b1;
    localparam int         PLAN_LEN      = 36;

    localparam logic [2:0] RG_MODE = hbp_pkg::REG_MODE;
    localparam logic [2:0] RG_BIM  = hbp_pkg::REG_BIMODAL_BITS;
    localparam logic [2:0] RG_GSH  = hbp_pkg::REG_GSHARE_BITS;
    localparam logic [2:0] RG_HIST = hbp_pkg::REG_HISTORY_BITS;
    localparam logic [2:0] RG_CHS  = hbp_pkg::REG_CHOOSER_BITS;

    typedef struct packed {
        logic        pred;
        logic        miss;
        logic        used_g;
        logic [31:0] total;
        logic [31:0] misses;
    } t_outcome;

    typedef struct packed {
        bit          is_cfg;
        logic [2:0]  reg_idx;
        logic [31:0] value;
        logic [31:0] pc;
        logic        tk;
        bit          has_exp;
        t_outcome    exp;
    } t_step_row;

    typedef struct packed {
        bit       has_exp;
        t_outcome exp;
    } t_row_note;

    localparam t_outcome NO_CHECK = '0;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [hbp_pkg::APB_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    hbp_br_if  br ();
    hbp_res_if res ();

    hybrid_branch_predictor uut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_branch (br),
        .o_result (res),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // model state
    hbp_pkg::t_cfg cfg;
    logic [1:0]  bim_ctr [0:(1<<BIM_MAX)-1];
    logic [1:0]  gsh_ctr [0:(1<<GSH_MAX)-1];
    logic [1:0]  chs_ctr [0:(1<<CHS_MAX)-1];
    logic [31:0] ghist;
    logic [31:0] branch_total;
    logic [31:0] miss_total;

    t_outcome    pending [$];
    t_row_note   row_notes [$];
    int          err_cnt = 0;
    int          idle_cycles = 0;
    bit          tx_idle_ok;
    bit          rx_idle_ok;
    int          rx_hold_cycles = 0;

    logic [31:0] pool_pc     [0:15];
    int unsigned pool_period [0:15];
    int unsigned pool_iter   [0:15];

    t_step_row plan [0:PLAN_LEN-1] = '{
        '{ITEM_ROW, RG_MODE, 32'd0, 32'h0000_0000, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 32'd1, 32'd0}},
        '{ITEM_ROW, RG_MODE, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b1, '{1'b1, 1'b1, 1'b0, 32'd2, 32'd1}},
        '{ITEM_ROW, RG_MODE, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 32'd3, 32'd1}},
        '{ITEM_ROW, RG_MODE, 32'd0, 32'h0000_4003, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 32'd4, 32'd1}},
        '{CFG_ROW,  RG_MODE, 32'd3, 32'h0, 1'b0, 1'b0, NO_CHECK},
        '{ITEM_ROW, RG_MODE, 32'd0, 32'h0000_0000, 1'b0, 1'b1, '{1'b1, 1'b1, 1'b0, 32'd5, 32'd2}},
        '{CFG_ROW,  RG_MODE, 32'd1, 32'h0, 1'b0, 1'b0, NO_CHECK},
        '{ITEM_ROW, RG_MODE, 32'd0, 32'h1234_5678, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b1, 32'd6, 32'd2}},
        '{ITEM_ROW, RG_MODE, 32'd0, 32'h1234_5678, 1'b0, 1'b0, NO_CHECK},
        '{ITEM_ROW, RG_MODE, 32'd0, 32'h1234_5678, 1'b0, 1'b0, NO_CHECK},
        '{CFG_ROW,  RG_HIST, 32'd15, 32'h0, 1'b0, 1'b0, NO_CHECK},
        '{ITEM_ROW, RG_MODE, 32'd0, 32'h8765_4321, 1'b1, 1'b0, NO_CHECK},
        '{ITEM_ROW, RG_MODE, 32'd0, 32'hFFFF_FFFC, 1'b0, 1'b0, NO_CHECK},
        '{CFG_ROW,  RG_GSH, 32'd0, 32'h0, 1'b0, 1'b0, NO_CHECK},
        '{ITEM_ROW, RG_MODE, 32'd0, 32'hA5A5_A5A5, 1'b0, 1'b0, NO_CHECK},
        '{ITEM_ROW, RG_MODE, 32'd0, 32'h5A5A_5A5A, 1'b0, 1'b0, NO_CHECK},
        '{CFG_ROW,  RG_GSH, 32'd15, 32'h0, 1'b0, 1'b0, NO_CHECK},
        '{CFG_ROW,  RG_HIST, 32'd0, 32'h0, 1'b0, 1'b0, NO_CHECK},
        '{ITEM_ROW, RG_MODE, 32'd0, 32'h0000_0FFC, 1'b1, 1'b0, NO_CHECK},
        '{ITEM_ROW, RG_MODE, 32'd0, 32'h0000_0FFC, 1'b1, 1'b0, NO_CHECK},
        '{CFG_ROW,  RG_HIST, 32'd4, 32'h0, 1'b0, 1'b0, NO_CHECK},
        '{ITEM_ROW, RG_MODE, 32'd0, 32'h0000_1234, 1'b0, 1'b0, NO_CHECK},
        '{CFG_ROW,  RG_MODE, 32'd2, 32'h0, 1'b0, 1'b0, NO_CHECK},
        '{CFG_ROW,  RG_CHS, 32'd0, 32'h0, 1'b0, 1'b0, NO_CHECK},
        '{CFG_ROW,  RG_BIM, 32'd0, 32'h0, 1'b0, 1'b0, NO_CHECK},
        '{ITEM_ROW, RG_MODE, 32'd0, 32'h0000_0000, 1'b0, 1'b0, NO_CHECK},
        '{ITEM_ROW, RG_MODE, 32'd0, 32'h7FFF_FFFF, 1'b0, 1'b0, NO_CHECK},
        '{ITEM_ROW, RG_MODE, 32'd0, 32'h8000_0000, 1'b1, 1'b0, NO_CHECK},
        '{ITEM_ROW, RG_MODE, 32'd0, 32'h0000_0010, 1'b0, 1'b0, NO_CHECK},
        '{ITEM_ROW, RG_MODE, 32'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, NO_CHECK},
        '{CFG_ROW,  RG_CHS, 32'd13, 32'h0, 1'b0, 1'b0, NO_CHECK},
        '{CFG_ROW,  RG_BIM, 32'd14, 32'h0, 1'b0, 1'b0, NO_CHECK},
        '{ITEM_ROW, RG_MODE, 32'd0, 32'h0000_0004, 1'b1, 1'b0, NO_CHECK},
        '{ITEM_ROW, RG_MODE, 32'd0, 32'h0000_0004, 1'b0, 1'b0, NO_CHECK},
        '{ITEM_ROW, RG_MODE, 32'd0, 32'h0000_3FFC, 1'b1, 1'b0, NO_CHECK},
        '{ITEM_ROW, RG_MODE, 32'd0, 32'h0000_4000, 1'b0, 1'b0, NO_CHECK}
    };

    function automatic logic [1:0] ctr_next(input logic [1:0] c, input logic up);
        if (up) return (c == 2'b11) ? c : c + 2'd1;
        return (c == 2'b00) ? c : c - 2'd1;
    endfunction

    function automatic int unsigned clamp_to(input int unsigned v, input int unsigned hi);
        return (v > hi) ? hi : v;
    endfunction

    function automatic t_outcome predict_branch(input logic [31:0] pc, input logic tk);
        t_outcome    o;
        int unsigned a, bb, gb, cb, hb, hv, bi, gi, ci;
        logic        bp, gp, ug, pr;
        a  = pc >> 2;
        bb = clamp_to(cfg.bimodal_index_bits, BIM_MAX);
        gb = clamp_to(cfg.gshare_index_bits, GSH_MAX);
        cb = clamp_to(cfg.chooser_index_bits, CHS_MAX);
        hb = clamp_to(cfg.history_bits, gb);
        hv = ghist & ((32'd1 << hb) - 1);
        bi = a & ((32'd1 << bb) - 1);
        ci = a & ((32'd1 << cb) - 1);
        gi = ((hv << (gb - hb)) ^ a) & ((32'd1 << gb) - 1);
        bp = bim_ctr[bi] >= hbp_pkg::CTR_WEAK_TAKEN;
        gp = gsh_ctr[gi] >= hbp_pkg::CTR_WEAK_TAKEN;
        if (cfg.mode == hbp_pkg::MODE_GSHARE) ug = 1'b1;
        else if (cfg.mode == hbp_pkg::MODE_HYBRID) ug = chs_ctr[ci] >= hbp_pkg::CTR_WEAK_TAKEN;
        else ug = 1'b0;
        pr = ug ? gp : bp;
        if (ug) gsh_ctr[gi] = ctr_next(gsh_ctr[gi], tk);
        else bim_ctr[bi] = ctr_next(bim_ctr[bi], tk);
        if (cfg.mode == hbp_pkg::MODE_HYBRID && gp != bp)
            chs_ctr[ci] = ctr_next(chs_ctr[ci], gp == tk);
        if ((cfg.mode == hbp_pkg::MODE_GSHARE || cfg.mode == hbp_pkg::MODE_HYBRID)
            && hb != 0) begin
            hv = hv >> 1;
            if (tk) hv = hv | (32'd1 << (hb - 1));
            ghist = hv;
        end
        if (branch_total != '1) branch_total = branch_total + 1;
        if (pr != tk && miss_total != '1) miss_total = miss_total + 1;
        o.pred   = pr;
        o.miss   = pr != tk;
        o.used_g = ug;
        o.total  = branch_total;
        o.misses = miss_total;
        return o;
    endfunction

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            hbp_pkg::REG_MODE:         cfg.mode               = val[1:0];
            hbp_pkg::REG_BIMODAL_BITS: cfg.bimodal_index_bits = val[3:0];
            hbp_pkg::REG_GSHARE_BITS:  cfg.gshare_index_bits  = val[3:0];
            hbp_pkg::REG_HISTORY_BITS: cfg.history_bits       = val[3:0];
            hbp_pkg::REG_CHOOSER_BITS: cfg.chooser_index_bits = val[3:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic settle();
        br.valid <= 1'b0;
        @(posedge clk);
        while (pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic send_branch(input logic [31:0] pc, input logic tk);
        int gap;
        gap = 0;
        if (tx_idle_ok && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 13);
        if (gap != 0) begin
            br.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        br.valid          <= 1'b1;
        br.branch_address <= pc;
        br.taken          <= tk;
        do @(posedge clk); while (br.ready !== 1'b1);
    endtask

    task automatic next_branch(output logic [31:0] pc, output logic tk);
        int unsigned r, k;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, 15);
        if (r < 70) begin
            // loop-style branch: taken except on the last trip
            pc = pool_pc[k];
            tk = (pool_iter[k] % pool_period[k]) != (pool_period[k] - 1);
            pool_iter[k]++;
        end else if (r < 82) begin
            pc = pool_pc[k] ^ ($urandom_range(0, 15) << $urandom_range(0, 28));
            tk = $urandom_range(0, 1);
        end else begin
            pc = $urandom;
            tk = $urandom_range(0, 1);
        end
    endtask

    function automatic logic [31:0] pick_bits(input int ph);
        int unsigned r;
        if (ph == 0) return 32'd15;
        if (ph == 1) return 32'd0;
        r = $urandom_range(0, 9);
        case (r)
            0: return 32'd0;
            1: return 32'd15;
            2: return 32'd12;
            3: return 32'd1;
            default: return $urandom_range(0, 15);
        endcase
    endfunction

    function automatic logic [31:0] pick_mode(input int ph);
        int unsigned r;
        if (ph < 2) return {30'd0, hbp_pkg::MODE_HYBRID};
        r = $urandom_range(0, 9);
        if (r < 4) return {30'd0, hbp_pkg::MODE_HYBRID};
        if (r < 7) return {30'd0, hbp_pkg::MODE_GSHARE};
        if (r < 9) return {30'd0, hbp_pkg::MODE_BIMODAL};
        return {30'd0, MODE_BIM_ALT};
    endfunction

    // branch side: model update on each transfer
    always @(posedge clk) begin : take_branch
        t_outcome  guess;
        t_row_note note;
        if (rst_n === 1'b1 && br.valid === 1'b1 && br.ready === 1'b1) begin
            guess = predict_branch(br.branch_address, br.taken);
            if (row_notes.size() != 0) begin
                note = row_notes.pop_front();
                if (note.has_exp) guess = note.exp;
            end
            pending.push_back(guess);
        end
    end

    // result side: compare each transfer with the oldest prediction
    always @(posedge clk) begin : check_result
        t_outcome want;
        if (rst_n === 1'b1 && res.valid === 1'b1 && res.ready === 1'b1) begin
            if (pending.size() == 0) begin
                $error("unexpected result transfer");
                err_cnt++;
            end else begin
                want = pending.pop_front();
                if (res.predicted_taken !== want.pred) begin
                    $error("predicted_taken: expected %0d, got %0d", want.pred,
                           res.predicted_taken);
                    err_cnt++;
                end
                if (res.mispredicted !== want.miss) begin
                    $error("mispredicted: expected %0d, got %0d", want.miss, res.mispredicted);
                    err_cnt++;
                end
                if (res.used_gshare !== want.used_g) begin
                    $error("used_gshare: expected %0d, got %0d", want.used_g, res.used_gshare);
                    err_cnt++;
                end
                if (res.prediction_total !== want.total) begin
                    $error("prediction_total: expected %0d, got %0d", want.total,
                           res.prediction_total);
                    err_cnt++;
                end
                if (res.miss_total !== want.misses) begin
                    $error("miss_total: expected %0d, got %0d", want.misses, res.miss_total);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((br.valid === 1'b1 && br.ready === 1'b1) ||
            (res.valid === 1'b1 && res.ready === 1'b1)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result receiver
    initial begin
        res.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rx_hold_cycles > 0) begin
                res.ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
                res.ready <= 1'b1;
            end else if (rx_idle_ok && $urandom_range(0, 9) == 0) begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                res.ready <= 1'b1;
            end else begin
                res.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [31:0] pc;
        logic        tk;
        t_row_note   note_in;
        rst_n             <= 1'b0;
        br.valid          <= 1'b0;
        br.branch_address <= '0;
        br.taken          <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        tx_idle_ok = 1'b1;
        rx_idle_ok = 1'b1;
        for (int i = 0; i < (1 << BIM_MAX); i++) bim_ctr[i] = hbp_pkg::CTR_WEAK_TAKEN;
        for (int i = 0; i < (1 << GSH_MAX); i++) gsh_ctr[i] = hbp_pkg::CTR_WEAK_TAKEN;
        for (int i = 0; i < (1 << CHS_MAX); i++) chs_ctr[i] = hbp_pkg::CTR_FAVOR_BIMOD;
        ghist        = '0;
        branch_total = '0;
        miss_total   = '0;
        cfg.mode               = hbp_pkg::RST_MODE;
        cfg.bimodal_index_bits = hbp_pkg::RST_BIMOD_BITS;
        cfg.gshare_index_bits  = hbp_pkg::RST_GSH_BITS;
        cfg.history_bits       = hbp_pkg::RST_HIST_BITS;
        cfg.chooser_index_bits = hbp_pkg::RST_CHS_BITS;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < PLAN_LEN; i++) begin
            if (plan[i].is_cfg) begin
                settle();
                reg_write(plan[i].reg_idx, plan[i].value);
            end else begin
                note_in.has_exp = plan[i].has_exp;
                note_in.exp     = plan[i].exp;
                row_notes.push_back(note_in);
                send_branch(plan[i].pc, plan[i].tk);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            reg_write(hbp_pkg::REG_MODE, pick_mode(ph));
            reg_write(hbp_pkg::REG_BIMODAL_BITS, pick_bits(ph));
            reg_write(hbp_pkg::REG_GSHARE_BITS, pick_bits(ph));
            reg_write(hbp_pkg::REG_HISTORY_BITS, pick_bits(ph));
            reg_write(hbp_pkg::REG_CHOOSER_BITS, pick_bits(ph));
            for (int k = 0; k < 16; k++) begin
                pool_pc[k]     = $urandom;
                pool_period[k] = $urandom_range(1, 6);
                pool_iter[k]   = 0;
            end
            tx_idle_ok = (ph != PHASES - 1);
            rx_idle_ok = (ph != PHASES - 1);
            if (ph == 2) begin
                // stall the output long enough to back up the pipeline
                tx_idle_ok     = 1'b0;
                rx_hold_cycles = HOLD_CYC;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                next_branch(pc, tk);
                send_branch(pc, tk);
            end
        end

        br.valid <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (err_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
